### rtl/ojcd_pkg.sv
`timescale 1ns / 1ps
package ojcd_pkg;

  localparam int TIME_W = 32;
  localparam int SPD_W  = 16;
  localparam int TERM_W = 24;
  // |dv| * 1000 with |dv| <= 65535
  localparam int NUM_W  = 26;
  localparam int CFG_W  = 20;
  localparam int CFG_AW = 3;

  localparam logic [CFG_AW-1:0] CFG_LIN_LIMIT   = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_ANG_LIMIT   = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_DECEL_LIMIT = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_FRESH_WIN   = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_GAP_LIMIT   = 3'd4;

  localparam logic [15:0]        LIN_LIMIT_RST   = 16'd300;
  localparam logic [15:0]        ANG_LIMIT_RST   = 16'd523;
  localparam logic signed [14:0] DECEL_LIMIT_RST = -15'sd100;
  localparam logic [15:0]        FRESH_WIN_RST   = 16'd200;
  localparam logic [19:0]        GAP_LIMIT_RST   = 20'd1500;

  localparam logic [9:0] MS_PER_S = 10'd1000;

  typedef struct packed {
    logic capture;
    logic cmd_push;
    logic t_prep;
    logic c_prep;
    logic div_start;
    logic t_write;
    logic odom_upd;
    logic f_init;
    logic f_step;
    logic gap_mul;
    logic gap_cmp;
    logic out_load;
  } ojcd_cmd_t;

  typedef struct packed {
    logic op;
    logic first;
    logic dt_zero;
    logic div_done;
    logic coll_ready;
    logic cacc_ok;
    logic f_done;
  } ojcd_stat_t;

endpackage

### rtl/odometry_jump_and_collision_detector.sv
`timescale 1ns / 1ps
// Odometry jump and collision detector. Command-velocity items (tuser = 1) update a
// three-deep command history and yield nothing; odometry items (tuser = 0) yield one
// result transaction with jump_fault (speed step past a limit since the previous
// odometry sample) and collided (the slow and fast means of the per-sample acceleration
// ring differ past the gap limit while the command is fresh and not decelerating).
// One transaction at a time: s_axis_tready is high only in the idle state, so the next
// item is accepted only after the current one is done. A command only updates the
// history; an odometry item runs the divider, the ring update and, when the histories
// are full, the collision evaluation; its result waits while an earlier result is
// still stalled on m_axis_tready. The shared radix-2 divider gives 26 quotient bits and
// runs once for the acceleration term and once for the command acceleration. The first
// odometry sample, and a zero time interval, skip the divider.
// The ring of SLOW_WINDOW terms sits in a single-port-write RAM read one entry per cycle.
// Configuration registers (cfg_addr_i): 0 linear jump limit, 1 angular jump limit,
// 2 deceleration limit (signed), 3 freshness window, 4 acceleration gap limit.
module odometry_jump_and_collision_detector
  import ojcd_pkg::*;
#(
  parameter int SLOW_WINDOW = 30,
  parameter int FAST_WINDOW = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // sample_time[31:0], arrival_time[63:32], linear_speed[79:64], angular_speed[95:80]
  input  logic [95:0]       s_axis_tdata,
  // op: 0 odometry, 1 command
  input  logic              s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // jump_fault[0], collided[1], zero fill[7:2]
  output logic [7:0]        m_axis_tdata,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i
);

  ojcd_cmd_t  cmd;
  ojcd_stat_t stat;
  logic [1:0] out_data;

  // sequencing: accept, divide, update the ring, evaluate, present
  ojcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (stat),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .cmd_o      (cmd)
  );

  // history, ring, divider and compare logic
  ojcd_dp #(
    .SLOW_WINDOW (SLOW_WINDOW),
    .FAST_WINDOW (FAST_WINDOW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (s_axis_tdata),
    .in_op_i     (s_axis_tuser),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_data_o  (out_data)
  );

  assign m_axis_tdata = {6'b0, out_data};

endmodule

### rtl/ojcd_ram.sv
`timescale 1ns / 1ps
module ojcd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 30
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/ojcd_div.sv
`timescale 1ns / 1ps
module ojcd_div
  import ojcd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [TIME_W-1:0] den_i,
  output logic              done_o,
  output logic [NUM_W-1:0]  quo_o
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [CW-1:0]     cnt_q, cnt_d;
  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [TIME_W-1:0] rem_q, rem_d;
  logic [TIME_W:0]   trial;

  // restoring division, one quotient bit a cycle
  always_comb begin
    trial = {rem_q, quo_q[NUM_W-1]};
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    if (start_i) begin
      cnt_d = CW'(NUM_W);
      quo_d = num_i;
      rem_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (trial >= {1'b0, den_i}) begin
        rem_d = TIME_W'(trial - {1'b0, den_i});
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial[TIME_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o = (cnt_q == '0);
  assign quo_o  = quo_q;

endmodule

### rtl/ojcd_dp.sv
`timescale 1ns / 1ps
module ojcd_dp
  import ojcd_pkg::*;
#(
  parameter int SLOW_WINDOW = 30,
  parameter int FAST_WINDOW = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ojcd_cmd_t         cmd_i,
  output ojcd_stat_t        stat_o,
  input  logic [95:0]       in_data_i,
  input  logic              in_op_i,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  output logic [1:0]        out_data_o
);

  localparam int PTR_W  = $clog2(SLOW_WINDOW);
  localparam int CNT_W  = $clog2(SLOW_WINDOW + 2);
  localparam int K_W    = $clog2(FAST_WINDOW + 1);
  localparam int SUM_W  = TERM_W + $clog2(SLOW_WINDOW + 1);
  localparam int FSUM_W = TERM_W + $clog2(FAST_WINDOW + 1);
  localparam int DIFF_W = TERM_W + $clog2(SLOW_WINDOW + 1) + $clog2(FAST_WINDOW + 1) + 1;
  localparam int GAP_W  = CFG_W + $clog2(SLOW_WINDOW * FAST_WINDOW + 1);
  localparam int CMP_W  = (DIFF_W > GAP_W) ? DIFF_W : GAP_W;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOW_WINDOW + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(SLOW_WINDOW - 1);
  localparam logic signed [TERM_W-1:0] TERM_MAX = {1'b0, {(TERM_W-1){1'b1}}};
  localparam logic signed [TERM_W-1:0] TERM_MIN = {1'b1, {(TERM_W-1){1'b0}}};
  localparam logic signed [DIFF_W-1:0] FAST_C = DIFF_W'(FAST_WINDOW);
  localparam logic signed [DIFF_W-1:0] SLOW_C = DIFF_W'(SLOW_WINDOW);
  localparam logic [GAP_W-1:0] WIN_PROD = GAP_W'(SLOW_WINDOW * FAST_WINDOW);

  // configuration
  logic [15:0]        lin_lim_q, ang_lim_q, fresh_win_q;
  logic signed [14:0] decel_q;
  logic [19:0]        gap_lim_q;

  // captured item
  logic                     op_q;
  logic [TIME_W-1:0]        stime_q, now_q;
  logic signed [SPD_W-1:0]  lin_q, ang_q;

  // odometry and command history
  logic [TIME_W-1:0]        last_time_q;
  logic signed [SPD_W-1:0]  last_lin_q, last_ang_q;
  logic [CNT_W-1:0]         odom_cnt_q;
  logic [PTR_W-1:0]         ptr_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic [TIME_W-1:0]        ct_q [3];
  logic signed [SPD_W-1:0]  cs_q [3];
  logic [2:0]               cmd_cnt_q;

  // work registers
  logic                     jump_q, coll_q, fresh_ok_q;
  logic [NUM_W-1:0]         num_q;
  logic [TIME_W-1:0]        den_q;
  logic                     neg_q, nz_q, numneg_q, dtz_q;
  logic [PTR_W-1:0]         idx_q;
  logic [K_W-1:0]           k_q;
  logic signed [FSUM_W-1:0] fsum_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic [1:0]               out_q;

  logic                     div_done;
  logic [NUM_W-1:0]         quo;
  logic [TERM_W-1:0]        rdata;
  logic signed [TERM_W-1:0] rd_term, old_term, term;
  logic [PTR_W-1:0]         raddr;

  logic signed [SPD_W:0]    dv, da;
  logic [SPD_W:0]           dv_mag, da_mag;
  logic [TIME_W-1:0]        dt, dt_mag, age, age_mag;
  logic signed [NUM_W:0]    cacc;
  logic [DIFF_W-1:0]        diff_mag;
  logic [GAP_W-1:0]         gap_prod;

  always_comb begin
    if (cmd_i.c_prep) begin
      dv = {cs_q[2][SPD_W-1], cs_q[2]} - {cs_q[0][SPD_W-1], cs_q[0]};
      dt = ct_q[2] - ct_q[0];
    end else begin
      dv = {lin_q[SPD_W-1], lin_q} - {last_lin_q[SPD_W-1], last_lin_q};
      dt = stime_q - last_time_q;
    end
    da      = {ang_q[SPD_W-1], ang_q} - {last_ang_q[SPD_W-1], last_ang_q};
    dv_mag  = dv[SPD_W] ? 17'(-dv) : 17'(dv);
    da_mag  = da[SPD_W] ? 17'(-da) : 17'(da);
    dt_mag  = dt[TIME_W-1] ? -dt : dt;
    age     = ct_q[2] - now_q;
    age_mag = age[TIME_W-1] ? -age : age;
  end

  // saturated acceleration term from the divider result
  always_comb begin
    if (dtz_q) begin
      term = !nz_q ? '0 : (numneg_q ? TERM_MIN : TERM_MAX);
    end else if (neg_q) begin
      term = (quo > NUM_W'(TERM_MAX) + 1'b1) ? TERM_MIN : -quo[TERM_W-1:0];
    end else begin
      term = (quo > NUM_W'(TERM_MAX)) ? TERM_MAX : quo[TERM_W-1:0];
    end
  end

  assign rd_term  = rdata;
  assign old_term = (odom_cnt_q == FULL_CNT) ? rd_term : '0;
  assign cacc     = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign diff_mag = diff_q[DIFF_W-1] ? DIFF_W'(-diff_q) : DIFF_W'(diff_q);
  assign gap_prod = GAP_W'(gap_lim_q) * WIN_PROD;
  assign raddr    = cmd_i.f_step ? idx_q : ptr_q;

  always_comb begin
    stat_o.op         = op_q;
    stat_o.first      = (odom_cnt_q == '0);
    stat_o.dt_zero    = dtz_q;
    stat_o.div_done   = div_done;
    stat_o.coll_ready = (cmd_cnt_q == 3'd4) && (odom_cnt_q == FULL_CNT);
    stat_o.cacc_ok    = fresh_ok_q &&
                        (dtz_q ? (nz_q ? !numneg_q : decel_q[14])
                               : (cacc > (NUM_W+1)'(decel_q)));
    stat_o.f_done     = (k_q == K_W'(FAST_WINDOW));
  end

  // configuration and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_lim_q   <= LIN_LIMIT_RST;
      ang_lim_q   <= ANG_LIMIT_RST;
      decel_q     <= DECEL_LIMIT_RST;
      fresh_win_q <= FRESH_WIN_RST;
      gap_lim_q   <= GAP_LIMIT_RST;
      last_time_q <= '0;
      last_lin_q  <= '0;
      last_ang_q  <= '0;
      odom_cnt_q  <= '0;
      ptr_q       <= '0;
      sum_q       <= '0;
      cmd_cnt_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_LIN_LIMIT:   lin_lim_q   <= cfg_wdata_i[15:0];
          CFG_ANG_LIMIT:   ang_lim_q   <= cfg_wdata_i[15:0];
          CFG_DECEL_LIMIT: decel_q     <= cfg_wdata_i[14:0];
          CFG_FRESH_WIN:   fresh_win_q <= cfg_wdata_i[15:0];
          CFG_GAP_LIMIT:   gap_lim_q   <= cfg_wdata_i[19:0];
          default: ;
        endcase
      end
      if (cmd_i.cmd_push && cmd_cnt_q != 3'd4) begin
        cmd_cnt_q <= cmd_cnt_q + 1'b1;
      end
      if (cmd_i.t_write) begin
        sum_q <= sum_q - SUM_W'(old_term) + SUM_W'(term);
        ptr_q <= (ptr_q == LAST_PTR) ? '0 : ptr_q + 1'b1;
      end
      if (cmd_i.odom_upd) begin
        last_time_q <= stime_q;
        last_lin_q  <= lin_q;
        last_ang_q  <= ang_q;
        if (odom_cnt_q != FULL_CNT) begin
          odom_cnt_q <= odom_cnt_q + 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= in_op_i;
      stime_q <= in_data_i[31:0];
      now_q   <= in_data_i[63:32];
      lin_q   <= in_data_i[79:64];
      ang_q   <= in_data_i[95:80];
      jump_q  <= 1'b0;
      coll_q  <= 1'b0;
    end
    if (cmd_i.cmd_push) begin
      ct_q[0] <= ct_q[1];
      ct_q[1] <= ct_q[2];
      ct_q[2] <= now_q;
      cs_q[0] <= cs_q[1];
      cs_q[1] <= cs_q[2];
      cs_q[2] <= lin_q;
    end
    if (cmd_i.t_prep || cmd_i.c_prep) begin
      num_q    <= NUM_W'(dv_mag[SPD_W-1:0]) * NUM_W'(MS_PER_S);
      den_q    <= dt_mag;
      neg_q    <= dv[SPD_W] ^ dt[TIME_W-1];
      nz_q     <= (dv != '0);
      numneg_q <= dv[SPD_W];
      dtz_q    <= (dt == '0);
    end
    if (cmd_i.t_prep) begin
      jump_q <= (odom_cnt_q != '0) &&
                ((dv_mag > {1'b0, lin_lim_q}) || (da_mag > {1'b0, ang_lim_q}));
    end
    if (cmd_i.c_prep) begin
      fresh_ok_q <= (age_mag < TIME_W'(fresh_win_q));
    end
    if (cmd_i.f_init) begin
      idx_q  <= (ptr_q == '0) ? LAST_PTR : ptr_q - 1'b1;
      k_q    <= '0;
      fsum_q <= '0;
    end
    if (cmd_i.f_step) begin
      idx_q <= (idx_q == '0) ? LAST_PTR : idx_q - 1'b1;
      k_q   <= k_q + 1'b1;
      if (k_q != '0) begin
        fsum_q <= fsum_q + FSUM_W'(rd_term);
      end
    end
    if (cmd_i.gap_mul) begin
      diff_q <= DIFF_W'(sum_q) * FAST_C - DIFF_W'(fsum_q) * SLOW_C;
    end
    if (cmd_i.gap_cmp) begin
      coll_q <= (CMP_W'(diff_mag) > CMP_W'(gap_prod));
    end
    if (cmd_i.out_load) begin
      out_q <= {coll_q, jump_q};
    end
  end

  ojcd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  ojcd_ram #(
    .WIDTH (TERM_W),
    .DEPTH (SLOW_WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.t_write),
    .waddr_i (ptr_q),
    .wdata_i (term),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign out_data_o = out_q;

endmodule

### rtl/ojcd_ctrl.sv
`timescale 1ns / 1ps
module ojcd_ctrl
  import ojcd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ojcd_stat_t stat_i,
  input  logic       s_tvalid_i,
  output logic       s_tready_o,
  output logic       m_tvalid_o,
  input  logic       m_tready_i,
  output ojcd_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CAP    = 4'd1;
  localparam logic [3:0] S_TSTART = 4'd2;
  localparam logic [3:0] S_TWAIT  = 4'd3;
  localparam logic [3:0] S_TWR    = 4'd4;
  localparam logic [3:0] S_UPD    = 4'd5;
  localparam logic [3:0] S_CHK    = 4'd6;
  localparam logic [3:0] S_CSTART = 4'd7;
  localparam logic [3:0] S_CWAIT  = 4'd8;
  localparam logic [3:0] S_CCHK   = 4'd9;
  localparam logic [3:0] S_FSUM   = 4'd10;
  localparam logic [3:0] S_GMUL   = 4'd11;
  localparam logic [3:0] S_GCMP   = 4'd12;
  localparam logic [3:0] S_OUT    = 4'd13;

  logic [3:0] state_q, state_d;
  logic       mvalid_q, mvalid_d;
  logic       out_free;

  assign out_free = !mvalid_q || m_tready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CAP;
        end
      end
      S_CAP: begin
        if (stat_i.op) begin
          cmd_o.cmd_push = 1'b1;
          state_d        = S_IDLE;
        end else begin
          cmd_o.t_prep = 1'b1;
          state_d      = S_TSTART;
        end
      end
      S_TSTART: begin
        if (stat_i.first) begin
          state_d = S_UPD;
        end else if (stat_i.dt_zero) begin
          state_d = S_TWR;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_TWAIT;
        end
      end
      S_TWAIT: begin
        if (stat_i.div_done) begin
          state_d = S_TWR;
        end
      end
      S_TWR: begin
        cmd_o.t_write = 1'b1;
        state_d       = S_UPD;
      end
      S_UPD: begin
        cmd_o.odom_upd = 1'b1;
        state_d        = S_CHK;
      end
      S_CHK: begin
        if (stat_i.coll_ready) begin
          cmd_o.c_prep = 1'b1;
          state_d      = S_CSTART;
        end else begin
          state_d = S_OUT;
        end
      end
      S_CSTART: begin
        if (stat_i.dt_zero) begin
          state_d = S_CCHK;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_CWAIT;
        end
      end
      S_CWAIT: begin
        if (stat_i.div_done) begin
          state_d = S_CCHK;
        end
      end
      S_CCHK: begin
        if (stat_i.cacc_ok) begin
          cmd_o.f_init = 1'b1;
          state_d      = S_FSUM;
        end else begin
          state_d = S_OUT;
        end
      end
      S_FSUM: begin
        cmd_o.f_step = 1'b1;
        if (stat_i.f_done) begin
          state_d = S_GMUL;
        end
      end
      S_GMUL: begin
        cmd_o.gap_mul = 1'b1;
        state_d       = S_GCMP;
      end
      S_GCMP: begin
        cmd_o.gap_cmp = 1'b1;
        state_d       = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    mvalid_d = mvalid_q;
    if (cmd_o.out_load) begin
      mvalid_d = 1'b1;
    end else if (m_tready_i) begin
      mvalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      mvalid_q <= mvalid_d;
    end
  end

  assign s_tready_o = (state_q == S_IDLE);
  assign m_tvalid_o = mvalid_q;

endmodule

### rtl/ojcd_chk.sv
`timescale 1ns / 1ps
module ojcd_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata
);

  logic s_fire;
  assign s_fire = s_axis_tvalid && s_axis_tready;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one transaction in work: busy right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> !s_axis_tready)
    else $error("input accepted while busy");

  // no result can appear in the cycle after an accept
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> !$rose(m_axis_tvalid))
    else $error("result appeared too early");

  // fill bits stay clear
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:2] == 6'b0))
    else $error("nonzero fill bits");

endmodule

bind odometry_jump_and_collision_detector ojcd_chk u_chk (.*);

### sim/ojcd_result_checker.sv
`timescale 1ns / 1ps
module ojcd_result_checker
  import ojcd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [95:0]       s_axis_tdata,
  input  logic              s_axis_tuser,
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [7:0]        m_axis_tdata,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  output int                fail_count_o,
  output int                pending_o
);
  localparam int SLOW = 30;
  localparam int FAST = 5;
  localparam longint TERM_HI = 64'sd8388607;
  localparam longint TERM_LO = -64'sd8388608;

  typedef struct packed {
    logic collided;
    logic jump_fault;
  } flags_t;

  logic [15:0] lin_lim, ang_lim, fresh_win;
  longint      decel_lim;
  logic [19:0] gap_lim;

  logic [31:0] prev_time;
  longint      prev_lin, prev_ang;
  int          odo_seen;
  longint      ring [SLOW];
  int          ring_wr;
  longint      ring_sum;
  logic [31:0] cmd_t [3];
  longint      cmd_v [3];
  int          cmd_seen;

  flags_t expected_flags [$];

  function automatic longint wrap_diff(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return longint'($signed(d));
  endfunction

  function automatic longint mag(longint x);
    return x < 0 ? -x : x;
  endfunction

  // truncating rate with explicit zero-interval handling
  function automatic longint per_second(longint dv, longint dt, longint hi, longint lo);
    longint num;
    num = dv * 1000;
    if (dt == 0) return num > 0 ? hi : (num < 0 ? lo : 0);
    return num / dt;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  task automatic predict_odometry(logic [95:0] d);
    logic [31:0] st, now;
    longint lin, ang, term, cacc, fsum;
    flags_t f;
    st  = d[31:0];
    now = d[63:32];
    lin = longint'($signed(d[79:64]));
    ang = longint'($signed(d[95:80]));
    f = '0;
    if (odo_seen > 0) begin
      if (mag(lin - prev_lin) > lin_lim || mag(ang - prev_ang) > ang_lim) f.jump_fault = 1;
      term = per_second(lin - prev_lin, wrap_diff(st, prev_time), TERM_HI, TERM_LO);
      if (term > TERM_HI) term = TERM_HI;
      if (term < TERM_LO) term = TERM_LO;
      ring_sum -= ring[ring_wr];
      ring[ring_wr] = term;
      ring_sum += term;
      ring_wr = (ring_wr + 1) % SLOW;
    end
    prev_time = st;
    prev_lin = lin;
    prev_ang = ang;
    if (odo_seen < SLOW + 1) odo_seen++;
    if (cmd_seen >= 4 && odo_seen >= SLOW + 1) begin
      cacc = per_second(cmd_v[2] - cmd_v[0], wrap_diff(cmd_t[2], cmd_t[0]),
                        64'sh7fffffffffffffff, 64'sh8000000000000000);
      if (cacc > decel_lim && mag(wrap_diff(cmd_t[2], now)) < fresh_win) begin
        fsum = 0;
        for (int k = 0; k < FAST; k++) fsum += ring[(ring_wr + 2 * SLOW - 1 - k) % SLOW];
        if (mag(ring_sum * FAST - fsum * SLOW) > longint'(gap_lim) * SLOW * FAST)
          f.collided = 1;
      end
    end
    expected_flags = {expected_flags, f};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    flags_t want;
    if (!rst_ni) begin
      lin_lim = 300; ang_lim = 523; decel_lim = -100; fresh_win = 200; gap_lim = 1500;
      prev_time = 0; prev_lin = 0; prev_ang = 0; odo_seen = 0;
      foreach (ring[i]) ring[i] = 0;
      ring_wr = 0; ring_sum = 0; cmd_seen = 0;
      foreach (cmd_t[i]) begin cmd_t[i] = 0; cmd_v[i] = 0; end
      expected_flags.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_LIN_LIMIT:   lin_lim = cfg_wdata_i[15:0];
          CFG_ANG_LIMIT:   ang_lim = cfg_wdata_i[15:0];
          CFG_DECEL_LIMIT: decel_lim = longint'($signed(cfg_wdata_i[14:0]));
          CFG_FRESH_WIN:   fresh_win = cfg_wdata_i[15:0];
          CFG_GAP_LIMIT:   gap_lim = cfg_wdata_i[19:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_flags.size() == 0) begin
          report("unexpected result", m_axis_tdata, -1);
        end else begin
          want = expected_flags.pop_front();
          if (m_axis_tdata[0] !== want.jump_fault) report("jump_fault", m_axis_tdata[0], want.jump_fault);
          if (m_axis_tdata[1] !== want.collided) report("collided", m_axis_tdata[1], want.collided);
          if (m_axis_tdata[7:2] !== 6'd0) report("fill bits", m_axis_tdata[7:2], 0);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser) begin
          cmd_t[0] = cmd_t[1]; cmd_t[1] = cmd_t[2]; cmd_t[2] = s_axis_tdata[63:32];
          cmd_v[0] = cmd_v[1]; cmd_v[1] = cmd_v[2];
          cmd_v[2] = longint'($signed(s_axis_tdata[79:64]));
          if (cmd_seen < 4) cmd_seen++;
        end else begin
          predict_odometry(s_axis_tdata);
        end
      end
    end
    pending_o = expected_flags.size();
  end
endmodule

### sim/odometry_jump_and_collision_detector_tb.sv
`timescale 1ns / 1ps
module odometry_jump_and_collision_detector_tb;
  import ojcd_pkg::*;

  localparam int RANDOM_ITEMS = 2000;
  localparam int STALL_LIMIT  = 20000;

  logic              clk_i = 0;
  logic              rst_ni = 0;
  logic              s_axis_tvalid = 0;
  logic              s_axis_tready;
  logic [95:0]       s_axis_tdata = '0;
  logic              s_axis_tuser = 0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 0;
  logic [7:0]        m_axis_tdata;
  logic              cfg_we_i = 0;
  logic [CFG_AW-1:0] cfg_addr_i = '0;
  logic [CFG_W-1:0]  cfg_wdata_i = '0;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  bit long_hold = 0;
  bit sink_quiet = 0;

  // time base of the generated traffic, advanced per sample
  logic [31:0] clock_ms;
  logic [15:0] speed_now;

  always #2 clk_i = ~clk_i;

  odometry_jump_and_collision_detector dut (.*);

  ojcd_result_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Watchdog: count cycles in which no transaction moves on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Result sink: random backpressure, plus one long hold-off on request.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        m_axis_tready <= 0;
        repeat (400) @(posedge clk_i);
        long_hold = 0;
      end
      n = sink_quiet ? 0 : gap_len();
      if (n > 0) begin
        m_axis_tready <= 0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1;
      @(posedge clk_i);
    end
  end

  // Offer one transaction and hold it until accepted; hold valid across back-to-back sends.
  task automatic send_item(bit is_cmd, logic [31:0] st, logic [31:0] now,
                           logic [15:0] lin, logic [15:0] ang, bit no_gap);
    int n;
    n = no_gap ? 0 : gap_len();
    if (n > 0) begin
      s_axis_tvalid <= 0;
      repeat (n) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= is_cmd;
    s_axis_tdata  <= {ang, lin, now, st};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drop_valid();
    s_axis_tvalid <= 0;
    @(posedge clk_i);
  endtask

  // Drive one register write with the write enable high; the caller drops it after the last write.
  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we_i    <= 1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  // Drain: drop valid, wait for all results, then idle before the next phase.
  task automatic drain();
    drop_valid();
    while (pending != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  // Plausible motion: small speed steps, short sample intervals, occasional commands.
  task automatic motion_item(bit no_gap);
    int r;
    logic [31:0] dt;
    r = $urandom_range(0, 99);
    dt = $urandom_range(0, 99) < 3 ? 32'($urandom_range(0, 1)) : 32'($urandom_range(5, 40));
    clock_ms = clock_ms + dt;
    if (r < 8) begin
      speed_now = 16'($urandom);
    end else begin
      speed_now = speed_now + 16'($urandom_range(0, 200)) - 16'd100;
    end
    if (r >= 70 && r < 90) begin
      send_item(1, $urandom, clock_ms, speed_now + 16'($urandom_range(0, 60)),
                16'($urandom), no_gap);
    end else if (r >= 97) begin
      // broken sample: any field at all
      send_item(1'($urandom_range(0, 1)), $urandom, $urandom, 16'($urandom),
                16'($urandom), no_gap);
    end else begin
      send_item(0, clock_ms, clock_ms + $urandom_range(0, 5), speed_now, 16'($urandom),
                no_gap);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: first sample, field extremes, zero intervals, wrap of time.
    send_item(0, 32'd0, 32'd0, 16'h0000, 16'h0000, 0);
    send_item(0, 32'd0, 32'd0, 16'h7fff, 16'h8000, 0);
    send_item(0, 32'd0, 32'd0, 16'h8000, 16'h7fff, 0);
    send_item(0, 32'd0, 32'd0, 16'h8000, 16'h7fff, 0);
    send_item(0, 32'hffffffff, 32'hffffffff, 16'h7fff, 16'h0000, 0);
    send_item(0, 32'd1, 32'd2, 16'h8000, 16'hffff, 0);
    send_item(0, 32'h80000000, 32'h7fffffff, 16'h012c, 16'h020b, 0);
    send_item(1, 32'hffffffff, 32'd100, 16'h7fff, 16'hffff, 0);
    send_item(1, 32'h0, 32'd100, 16'h8000, 16'h0, 0);
    send_item(1, 32'h0, 32'd100, 16'h8000, 16'h0, 0);
    send_item(1, 32'h0, 32'hffffffff, 16'h7fff, 16'h0, 0);
    drain();

    // Settings sweep: reset values, extremes, then back toward typical values.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: ;
        1: begin
          write_reg(CFG_LIN_LIMIT, 20'd0);
          write_reg(CFG_ANG_LIMIT, 20'd0);
          write_reg(CFG_DECEL_LIMIT, 20'(-15'sd10000));
          write_reg(CFG_FRESH_WIN, 20'hffff);
          write_reg(CFG_GAP_LIMIT, 20'd0);
        end
        2: begin
          write_reg(CFG_LIN_LIMIT, 20'hffff);
          write_reg(CFG_ANG_LIMIT, 20'hffff);
          write_reg(CFG_DECEL_LIMIT, 20'd0);
          write_reg(CFG_FRESH_WIN, 20'd0);
          write_reg(CFG_GAP_LIMIT, 20'd1000000);
        end
        3: begin
          write_reg(CFG_FRESH_WIN, 20'hffff);
          write_reg(CFG_GAP_LIMIT, 20'd200);
          write_reg(CFG_DECEL_LIMIT, 20'(-15'sd10000));
          write_reg(CFG_LIN_LIMIT, 20'd100);
          write_reg(CFG_ANG_LIMIT, 20'hffff);
        end
        4: begin
          write_reg(CFG_GAP_LIMIT, 20'hfffff);
          write_reg(CFG_FRESH_WIN, 20'd50);
          write_reg(CFG_DECEL_LIMIT, 20'(-15'sd100));
          write_reg(CFG_LIN_LIMIT, 20'd300);
          write_reg(CFG_ANG_LIMIT, 20'd523);
        end
        default: begin
          write_reg(CFG_GAP_LIMIT, 20'd1500);
          write_reg(CFG_FRESH_WIN, 20'd200);
          write_reg(CFG_ANG_LIMIT, 20'd10);
          write_reg(CFG_DECEL_LIMIT, 20'($urandom_range(0, 10000)) ^ 20'h7fff);
        end
      endcase
      cfg_we_i <= 0;
      clock_ms = $urandom;
      speed_now = 16'($urandom);
      for (int i = 0; i < RANDOM_ITEMS / 6; i++) begin
        // once, let the sink stall for a long stretch while the source keeps offering
        if (phase == 3 && i == 40) long_hold = 1;
        // some stretches with no idling at all
        sink_quiet = (i % 100) >= 80;
        motion_item(sink_quiet);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

### odometry_jump_and_collision_detector.f
rtl/ojcd_pkg.sv
rtl/ojcd_ram.sv
rtl/ojcd_div.sv
rtl/ojcd_dp.sv
rtl/ojcd_ctrl.sv
rtl/odometry_jump_and_collision_detector.sv
rtl/ojcd_chk.sv
sim/ojcd_result_checker.sv
sim/odometry_jump_and_collision_detector_tb.sv
